/* hdl/awbs_pkg.sv */
// ----------------------------------------------------------------------------
// awbs_pkg
// Shared types, register indexes and constants of the affine warp sampler.
// ----------------------------------------------------------------------------
`default_nettype none
package awbs_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_COEF_XX      = 3'd0,
        REG_COEF_XY      = 3'd1,
        REG_COEF_XT      = 3'd2,
        REG_COEF_YX      = 3'd3,
        REG_COEF_YY      = 3'd4,
        REG_COEF_YT      = 3'd5,
        REG_IMAGE_WIDTH  = 3'd6,
        REG_IMAGE_HEIGHT = 3'd7
    } t_reg_idx;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;
    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    localparam logic signed [31:0] COEF_ONE = 32'sd65536;
    localparam int FRAC_BITS = 16;

endpackage
`default_nettype wire

/* hdl/affine_warp_bilinear_sampler_core.sv */
// A sample transfer gives a result at the output register; a load gives none.
// Throughput: one item per cycle while the output is not stalled; the source
//   store is four banks split on x and y parity so all bilinear neighbours
//   are read in the same cycle.
// Reset: synchronous, active low; clears valid bits and sets the identity
//   matrix and a 256 x 256 image. Store contents are undefined until loaded.
// ----------------------------------------------------------------------------
// affine_warp_bilinear_sampler_core
// Loads a four-bank source store and streams output pixels through an inverse
// affine map, sampling the store by nearest (floor) or bilinear interpolation.
// ----------------------------------------------------------------------------
`default_nettype none
module affine_warp_bilinear_sampler_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_PLANES = 4,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [awbs_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [awbs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_action,
    input  wire logic [7:0]                          i_pixel_x,
    input  wire logic [7:0]                          i_pixel_y,
    input  wire logic [1:0]                          i_plane,
    input  wire logic                                i_sample_mode,
    input  wire logic [15:0]                         i_load_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [15:0]                              o_sampled_value
);
    import awbs_pkg::*;

    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int PB = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int BXB = (XB > 1) ? XB - 1 : 1;
    localparam int BYB = (YB > 1) ? YB - 1 : 1;
    localparam int BANK_AW = PB + BYB + BXB;
    localparam int BANK_DEPTH = MAX_PLANES * (1 << BYB) * (1 << BXB);
    localparam int NS = 8;
    localparam int WRB = 2 + BANK_AW + PIXEL_BITS;

    // ---------------- configuration ----------------
    logic signed [31:0] r_coef [6];
    logic [8:0] r_w;
    logic [8:0] r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= COEF_ONE;
            r_coef[1] <= '0;
            r_coef[2] <= '0;
            r_coef[3] <= '0;
            r_coef[4] <= COEF_ONE;
            r_coef[5] <= '0;
            r_w <= 9'd256;
            r_h <= 9'd256;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_COEF_XX:      r_coef[0] <= i_cfg_data;
                REG_COEF_XY:      r_coef[1] <= i_cfg_data;
                REG_COEF_XT:      r_coef[2] <= i_cfg_data;
                REG_COEF_YX:      r_coef[3] <= i_cfg_data;
                REG_COEF_YY:      r_coef[4] <= i_cfg_data;
                REG_COEF_YT:      r_coef[5] <= i_cfg_data;
                REG_IMAGE_WIDTH:  r_w <= i_cfg_data[8:0];
                REG_IMAGE_HEIGHT: r_h <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // clamp to store size
    logic [13:0] w_eff;
    logic [13:0] h_eff;
    always_comb begin
        w_eff = (14'(r_w) > 14'(MAX_WIDTH))  ? 14'(MAX_WIDTH)  : 14'(r_w);
        h_eff = (14'(r_h) > 14'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : 14'(r_h);
    end

    // ---------------- pipeline control ----------------
    // Whole pipe advances together; output register holds when stalled.
    logic adv;
    logic [NS-1:0] r_v;
    assign adv = !(o_valid && i_stall);
    assign o_stall = !adv;

    logic in_fire;
    assign in_fire = i_valid && adv;

    // ---------------- stage 1: centre ----------------
    logic               r1_load;
    logic [XB-1:0]      r1_lx;
    logic [YB-1:0]      r1_ly;
    logic               r1_lok;
    logic [PB-1:0]      r1_lpl;
    logic [PIXEL_BITS-1:0] r1_lval;
    logic signed [23:0] r1_cx;   // Q8.1 style: pixel*2 - w, units of half pixel
    logic signed [23:0] r1_cy;
    logic [1:0]         r1_pl;
    logic               r1_mode;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_load <= i_action == ACT_LOAD;
            r1_lx   <= XB'(i_pixel_x);
            r1_ly   <= YB'(i_pixel_y);
            r1_lpl  <= PB'(i_plane);
            r1_lok  <= (32'(i_pixel_x) < 32'(MAX_WIDTH)) && (32'(i_pixel_y) < 32'(MAX_HEIGHT))
                       && (32'(i_plane) < 32'(MAX_PLANES));
            r1_lval <= PIXEL_BITS'(i_load_value);
            r1_cx   <= $signed({15'd0, i_pixel_x, 1'b0}) - $signed({10'd0, w_eff});
            r1_cy   <= $signed({15'd0, i_pixel_y, 1'b0}) - $signed({10'd0, h_eff});
            r1_pl   <= i_plane;
            r1_mode <= i_sample_mode;
        end
    end

    // ---------------- stage 2: products ----------------
    // cx in half pixels (Q.1) times Q16.16 coef gives Q.17 products.
    logic signed [55:0] r2_pxx, r2_pxy, r2_pyx, r2_pyy;
    logic [1:0] r2_pl;
    logic       r2_mode;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_pxx  <= 56'(r1_cx) * 56'(r_coef[0]);
            r2_pxy  <= 56'(r1_cy) * 56'(r_coef[1]);
            r2_pyx  <= 56'(r1_cx) * 56'(r_coef[3]);
            r2_pyy  <= 56'(r1_cy) * 56'(r_coef[4]);
            r2_pl   <= r1_pl;
            r2_mode <= r1_mode;
        end
    end

    // ---------------- stage 3: sums ----------------
    // Q.17 sums; the Q32.32 value is sum << 15, so its bits [31:16] (sum bits [16:1]) are the fraction.
    logic signed [57:0] sx, sy;
    always_comb begin
        sx = 58'(r2_pxx) + 58'(r2_pxy) + (58'(r_coef[2]) <<< 1) + (58'(w_eff) <<< 16);
        sy = 58'(r2_pyx) + 58'(r2_pyy) + (58'(r_coef[5]) <<< 1) + (58'(h_eff) <<< 16);
    end

    logic signed [40:0] r3_ix, r3_iy;
    logic [15:0] r3_fx, r3_fy;
    logic [1:0]  r3_pl;
    logic        r3_mode;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_ix   <= sx[57:17];
            r3_iy   <= sy[57:17];
            r3_fx   <= sx[16:1];
            r3_fy   <= sy[16:1];
            r3_pl   <= r2_pl;
            r3_mode <= r2_mode;
        end
    end

    // ---------------- stage 4: neighbour addresses ----------------
    // Neighbour k: dx = k[0], dy = k[1]. Bank b holds (x parity b[0], y parity b[1]).
    logic signed [41:0] nx [2];
    logic signed [41:0] ny [2];
    logic in_x [2];
    logic in_y [2];
    logic pl_ok;
    always_comb begin
        for (int d = 0; d < 2; d++) begin
            nx[d] = 42'(r3_ix) + 42'(d);
            ny[d] = 42'(r3_iy) + 42'(d);
            in_x[d] = (nx[d] >= 0) && (nx[d] < $signed(42'(w_eff)));
            in_y[d] = (ny[d] >= 0) && (ny[d] < $signed(42'(h_eff)));
        end
        pl_ok = 32'(r3_pl) < 32'(MAX_PLANES);
    end

    logic [BANK_AW-1:0] r4_addr [4];
    logic [3:0]  r4_ok;          // per bank
    logic [1:0]  r4_par;         // parity of ix, iy
    logic [15:0] r4_fx, r4_fy;
    logic        r4_mode;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int b = 0; b < 4; b++) begin
                // bank b parity px=b[0]; the neighbour with that parity has
                // dx = px ^ ix[0]
                logic dx;
                logic dy;
                logic [XB-1:0] xx;
                logic [YB-1:0] yy;
                dx = b[0] ^ r3_ix[0];
                dy = b[1] ^ r3_iy[0];
                xx = XB'(nx[dx]);
                yy = YB'(ny[dy]);
                r4_addr[b] <= {PB'(r3_pl), BYB'(yy >> 1), BXB'(xx >> 1)};
                r4_ok[b]   <= in_x[dx] && in_y[dy] && pl_ok;
            end
            r4_par  <= {r3_iy[0], r3_ix[0]};
            r4_fx   <= r3_fx;
            r4_fy   <= r3_fy;
            r4_mode <= r3_mode;
        end
    end

    // ---------------- source store: four banks ----------------
    logic [PIXEL_BITS-1:0] bank_q [4];
    logic [BANK_AW-1:0] wbaddr;
    logic [1:0] wbank;
    assign wbaddr = {r1_lpl, BYB'(r1_ly >> 1), BXB'(r1_lx >> 1)};
    assign wbank  = {r1_ly[0], r1_lx[0]};

    // Loads write from stage 4, the stage where samples read, so every
    // sample sees exactly the loads that were accepted before it.
    logic           r2_ld, r3_ld, r4_ld;
    logic [WRB-1:0] r2_wr, r3_wr, r4_wr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ld <= 1'b0;
            r3_ld <= 1'b0;
            r4_ld <= 1'b0;
        end else if (adv) begin
            r2_ld <= r_v[0] && r1_load && r1_lok;
            r3_ld <= r2_ld;
            r4_ld <= r3_ld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_wr <= {wbank, wbaddr, r1_lval};
            r3_wr <= r2_wr;
            r4_wr <= r3_wr;
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        awbs_ram #(.WIDTH(PIXEL_BITS), .DEPTH(BANK_DEPTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (adv && r4_ld && (r4_wr[WRB-1 -: 2] == 2'(b))),
            .i_waddr (r4_wr[PIXEL_BITS +: BANK_AW]),
            .i_wdata (r4_wr[PIXEL_BITS-1:0]),
            .i_re    (adv),
            .i_raddr (r4_addr[b]),
            .o_rdata (bank_q[b])
        );
    end

    // stage 5 sidebands (RAM data arrives with them)
    logic [3:0]  r5_ok;
    logic [1:0]  r5_par;
    logic [15:0] r5_fx, r5_fy;
    logic        r5_mode;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_ok <= r4_ok; r5_par <= r4_par;
            r5_fx <= r4_fx; r5_fy <= r4_fy; r5_mode <= r4_mode;
        end
    end

    // ---------------- stage 6: horizontal blend products ----------------
    logic [15:0] p [4];     // neighbour k
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            logic [1:0] bk;
            bk = 2'(k) ^ r5_par;
            p[k] = r5_ok[bk] ? 16'(bank_q[bk]) : 16'd0;
        end
    end

    logic [16:0] fxc;
    assign fxc = 17'd65536 - 17'(r5_fx);
    logic [32:0] r6_a [4];
    logic [15:0] r6_p0, r6_fy;
    logic        r6_mode;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_a[0] <= 33'(p[0]) * 33'(fxc);
            r6_a[1] <= 33'(p[1]) * 33'(r5_fx);
            r6_a[2] <= 33'(p[2]) * 33'(fxc);
            r6_a[3] <= 33'(p[3]) * 33'(r5_fx);
            r6_p0 <= p[0]; r6_fy <= r5_fy; r6_mode <= r5_mode;
        end
    end

    // ---------------- stage 7: vertical blend products ----------------
    logic [15:0] top, bot;
    assign top = 16'((r6_a[0] + r6_a[1]) >> 16);
    assign bot = 16'((r6_a[2] + r6_a[3]) >> 16);
    logic [16:0] fyc;
    assign fyc = 17'd65536 - 17'(r6_fy);
    logic [32:0] r7_t, r7_b;
    logic [15:0] r7_p0;
    logic        r7_mode;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_t <= 33'(top) * 33'(fyc);
            r7_b <= 33'(bot) * 33'(r6_fy);
            r7_p0 <= r6_p0; r7_mode <= r6_mode;
        end
    end

    // ---------------- stage 8: output register ----------------
    logic [33:0] vsum;
    assign vsum = 34'(r7_t) + 34'(r7_b);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_sampled_value <= (r7_mode == MODE_BILINEAR) ? vsum[31:16] : r7_p0;
        end
    end

    // valid chain: stage 0 = stage-1 register holds any item; samples only later
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NS-2:1], r_v[0] && !r1_load, in_fire};
        end
    end
    assign o_valid = r_v[NS-1];

    // ---------------- assertions ----------------
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sampled_value)))
        else $error("result lost under stall");
    a_stall_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output stall");
    a_load_nores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_v[0] && r1_load) |=> !r_v[1])
        else $error("load produced a result");
    a_sample_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_v[0] && !r1_load) |=> r_v[1])
        else $error("sample dropped");
endmodule
`default_nettype wire

/* hdl/awbs_ram.sv */
// ----------------------------------------------------------------------------
// awbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module awbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire
